FILE: rtl/afhp_pkg.sv
// Package with widths, codec codes and rate tables for the audio frame header parser.
package afhp_pkg;

    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 24;
    localparam int NUM_W     = 26;
    localparam int PROD_W    = 46;
    localparam int RECIP_SH  = 32;
    localparam int QUO_W     = 12;
    localparam int REM_W     = 17;

    typedef enum logic [2:0] {
        CODEC_NONE = 3'd0,
        CODEC_MPEG = 3'd1,
        CODEC_ADTS = 3'd2,
        CODEC_AC3  = 3'd3,
        CODEC_EAC3 = 3'd4,
        CODEC_LATM = 3'd5
    } codec_t;

    typedef struct packed {
        codec_t      codec;
        logic [13:0] size;
        logic        bad;
        logic        mpeg;
        logic        layer1;
        logic        pad;
        logic [3:0]  div_idx;
    } afhp_ctl_t;

    localparam logic [17:0] MULT_L1  = 18'd12000;
    localparam logic [17:0] MULT_L23 = 18'd144000;

    localparam logic [8:0] KBPS_TAB [2][3][16] = '{
        '{
            '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
              9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0},
            '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
              9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
            '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
              9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0}
        },
        '{
            '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
              9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0},
            '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
              9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0},
            '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
              9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0}
        }
    };

    // Sample rates after the version shift, and floor(2^32 / rate) for each.
    localparam logic [15:0] DIV_TAB [9] = '{
        16'd44100, 16'd48000, 16'd32000, 16'd22050, 16'd24000, 16'd16000,
        16'd11025, 16'd12000, 16'd8000
    };
    localparam logic [19:0] RECIP_TAB [9] = '{
        20'd97391, 20'd89478, 20'd134217, 20'd194783, 20'd178956, 20'd268435,
        20'd389566, 20'd357913, 20'd536870
    };

    localparam logic [10:0] AC3_WORDS [38][3] = '{
        '{11'd64, 11'd69, 11'd96}, '{11'd64, 11'd70, 11'd96},
        '{11'd80, 11'd87, 11'd120}, '{11'd80, 11'd88, 11'd120},
        '{11'd96, 11'd104, 11'd144}, '{11'd96, 11'd105, 11'd144},
        '{11'd112, 11'd121, 11'd168}, '{11'd112, 11'd122, 11'd168},
        '{11'd128, 11'd139, 11'd192}, '{11'd128, 11'd140, 11'd192},
        '{11'd160, 11'd174, 11'd240}, '{11'd160, 11'd175, 11'd240},
        '{11'd192, 11'd208, 11'd288}, '{11'd192, 11'd209, 11'd288},
        '{11'd224, 11'd243, 11'd336}, '{11'd224, 11'd244, 11'd336},
        '{11'd256, 11'd278, 11'd384}, '{11'd256, 11'd279, 11'd384},
        '{11'd320, 11'd348, 11'd480}, '{11'd320, 11'd349, 11'd480},
        '{11'd384, 11'd417, 11'd576}, '{11'd384, 11'd418, 11'd576},
        '{11'd448, 11'd487, 11'd672}, '{11'd448, 11'd488, 11'd672},
        '{11'd512, 11'd557, 11'd768}, '{11'd512, 11'd558, 11'd768},
        '{11'd640, 11'd696, 11'd960}, '{11'd640, 11'd697, 11'd960},
        '{11'd768, 11'd835, 11'd1152}, '{11'd768, 11'd836, 11'd1152},
        '{11'd896, 11'd975, 11'd1344}, '{11'd896, 11'd976, 11'd1344},
        '{11'd1024, 11'd1114, 11'd1536}, '{11'd1024, 11'd1115, 11'd1536},
        '{11'd1152, 11'd1253, 11'd1728}, '{11'd1152, 11'd1254, 11'd1728},
        '{11'd1280, 11'd1393, 11'd1920}, '{11'd1280, 11'd1394, 11'd1920}
    };

endpackage

FILE: rtl/audio_frame_header_parser.sv
// Audio frame header parser: sync detection, field checks and frame length pipeline.
// An input header passes through five register stages (decode, bitrate product,
// reciprocal product, remainder, output), which all advance together, at one
// header per cycle while the output is not stalled.
// A stalled output holds every stage, so nothing is lost or repeated.
// Reset clears all valid bits; payload registers are not reset.
module audio_frame_header_parser (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // Fields from bit 0: header_bytes[47:0], available_bytes[50:48], zero fill.
    input  logic [afhp_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // Fields from bit 0: codec[2:0], frame_size[16:3], header_invalid[17], zero fill.
    output logic [afhp_pkg::M_TDATA_W-1:0] m_tdata
);
    import afhp_pkg::*;

    logic        adv;
    logic [47:0] hdr;
    logic [2:0]  avail;
    logic [7:0]  b1, b2, b3, b4, b5;
    logic [23:0] w;
    logic        ge3, ge6;
    logic        hit_mpeg, hit_adts, hit_sync0b77, hit_ac3, hit_latm;
    logic [1:0]  ver, lcode, sri, lidx, shift;
    logic [3:0]  bri;
    logic        kbps_row;
    logic [5:0]  ac3_idx;
    logic [8:0]  kbps_next;
    afhp_ctl_t   ctl_next;

    logic        v1_reg, v2_reg, v3_reg, v4_reg, m_tvalid_reg;
    afhp_ctl_t   ctl1_reg, ctl2_reg, ctl3_reg, ctl4_reg;
    logic [8:0]  kbps1_reg;
    logic [26:0] num_full;
    logic [NUM_W-1:0] num2_reg, num3_reg;
    logic [PROD_W-1:0] prod_next, prod3_reg;
    logic [QUO_W-1:0]  quo_next, quo4_reg;
    logic [27:0] qd_full;
    logic [NUM_W-1:0]  rem_full;
    logic [REM_W-1:0]  rem4_reg;
    logic [QUO_W-1:0]  quo_fix;
    logic [QUO_W-1:0]  base;
    logic [13:0] size_next;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign hdr   = s_tdata[47:0];
    assign avail = s_tdata[50:48];
    assign b1    = hdr[39:32];
    assign b2    = hdr[31:24];
    assign b3    = hdr[23:16];
    assign b4    = hdr[15:8];
    assign b5    = hdr[7:0];
    assign w     = hdr[47:24];
    assign ge3   = (avail >= 3'd3);
    assign ge6   = (avail >= 3'd6);

    assign ver   = b1[4:3];
    assign lcode = b1[2:1];
    assign bri   = b2[7:4];
    assign sri   = b2[3:2];

    assign hit_mpeg = ge3 && (w[23:13] == 11'h7FF) && (w[12:11] != 2'b01)
                      && (w[10:9] != 2'b00) && (w[7:4] != 4'hF);
    assign hit_adts = ge3 && (w[23:12] == 12'hFFF) && (w[10:9] == 2'b00)
                      && (b2[5:2] != 4'hF);
    assign hit_sync0b77 = ge6 && (w[23:8] == 16'h0B77);
    assign hit_ac3  = hit_sync0b77 && (b5 <= 8'd80);
    assign hit_latm = ge3 && (w[23:13] == 11'h2B7);

    always_comb begin
        lidx     = (lcode == 2'd0) ? 2'd0 : 2'd3 - lcode;
        kbps_row = (ver != 2'd3);
        shift    = (ver == 2'd3) ? 2'd0 : ((ver == 2'd2) ? 2'd1 : 2'd2);
        ac3_idx  = (b4[5:0] > 6'd37) ? 6'd0 : b4[5:0];
        kbps_next = KBPS_TAB[kbps_row][lidx][bri];

        ctl_next         = '0;
        ctl_next.codec   = CODEC_NONE;
        ctl_next.layer1  = (lcode == 2'd3);
        ctl_next.pad     = b2[1];
        ctl_next.div_idx = {1'b0, shift, 1'b0} + {2'b00, shift} + {2'b00, sri};
        priority if (hit_mpeg) begin
            ctl_next.codec = CODEC_MPEG;
            ctl_next.mpeg  = 1'b1;
            ctl_next.bad   = (sri == 2'd3) || (kbps_next == 9'd0);
        end else if (hit_adts) begin
            ctl_next.codec = CODEC_ADTS;
            ctl_next.size  = {1'b0, b3[1:0], b4, b5[7:5]};
        end else if (hit_ac3) begin
            ctl_next.codec = CODEC_AC3;
            if (b4[7:6] == 2'd3 || b4[5:0] > 6'd37) begin
                ctl_next.bad = 1'b1;
            end else begin
                ctl_next.size = {2'b00, AC3_WORDS[ac3_idx][b4[7:6]], 1'b0};
            end
        end else if (hit_sync0b77) begin
            ctl_next.codec = CODEC_EAC3;
            if (b4[7:4] == 4'hF) begin
                ctl_next.bad = 1'b1;
            end else begin
                ctl_next.size = {1'b0, ({1'b0, b2[2:0], b3} + 12'd1), 1'b0};
            end
        end else if (hit_latm) begin
            ctl_next.codec = CODEC_LATM;
            ctl_next.size  = {1'b0, b1[4:0], b2} + 14'd3;
        end
    end

    assign num_full  = 27'(kbps1_reg) * 27'(ctl1_reg.layer1 ? MULT_L1 : MULT_L23);
    assign prod_next = PROD_W'(num2_reg) * PROD_W'(RECIP_TAB[ctl2_reg.div_idx]);
    assign quo_next  = prod3_reg[RECIP_SH +: QUO_W];
    assign qd_full   = 28'(quo_next) * 28'(DIV_TAB[ctl3_reg.div_idx]);
    assign rem_full  = num3_reg - qd_full[NUM_W-1:0];

    always_comb begin
        quo_fix = quo4_reg
                  + QUO_W'(rem4_reg >= {1'b0, DIV_TAB[ctl4_reg.div_idx]});
        base    = quo_fix + QUO_W'(ctl4_reg.pad);
        if (ctl4_reg.bad) begin
            size_next = 14'd0;
        end else if (ctl4_reg.mpeg) begin
            size_next = ctl4_reg.layer1 ? {base, 2'b00} : {2'b00, base};
        end else begin
            size_next = ctl4_reg.size;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            v4_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            v1_reg       <= s_tvalid;
            v2_reg       <= v1_reg;
            v3_reg       <= v2_reg;
            v4_reg       <= v3_reg;
            m_tvalid_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ctl1_reg    <= ctl_next;
            kbps1_reg   <= kbps_next;
            ctl2_reg    <= ctl1_reg;
            num2_reg    <= num_full[NUM_W-1:0];
            ctl3_reg    <= ctl2_reg;
            num3_reg    <= num2_reg;
            prod3_reg   <= prod_next;
            ctl4_reg    <= ctl3_reg;
            quo4_reg    <= quo_next;
            rem4_reg    <= rem_full[REM_W-1:0];
            m_tdata_reg <= {6'd0, ctl4_reg.bad, size_next, ctl4_reg.codec};
        end
    end

    a_invalid_no_size: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[17] |-> m_tdata[16:3] == 14'd0)
        else $error("invalid header reported with nonzero size");

    a_none_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2:0] == CODEC_NONE |-> m_tdata[17:3] == 15'd0)
        else $error("no codec but size or invalid flag set");

    a_codec_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[2:0] <= CODEC_LATM)
        else $error("codec code out of range");

    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        v4_reg && ctl4_reg.mpeg && !ctl4_reg.bad
        |-> rem4_reg < {DIV_TAB[ctl4_reg.div_idx], 1'b0})
        else $error("reciprocal quotient off by more than one");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

endmodule

FILE: sim/audio_frame_header_checker.sv
// Checker that predicts and compares the results of the audio frame header parser.
module audio_frame_header_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [55:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    output int          fail_count,
    output int          pending_count
);
    import afhp_pkg::*;

    typedef struct packed {
        codec_t      codec;
        logic [13:0] size;
        logic        bad;
    } parse_result_t;

    parse_result_t expected_results[$];

    function automatic int unsigned kbps_of(bit v1, int unsigned layer, int unsigned idx);
        int unsigned t1 [3][16] = '{
            '{0, 32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352, 384, 416, 448, 0},
            '{0, 32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384, 0},
            '{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 0}};
        int unsigned t2 [3][16] = '{
            '{0, 32, 48, 56, 64, 80, 96, 112, 128, 144, 160, 176, 192, 224, 256, 0},
            '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0},
            '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0}};
        return v1 ? t1[layer - 1][idx] : t2[layer - 1][idx];
    endfunction

    function automatic int unsigned ac3_size_words(int unsigned code, int unsigned fs);
        int unsigned base [19] = '{64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384,
                                   448, 512, 640, 768, 896, 1024, 1152, 1280};
        int unsigned b;
        b = base[code / 2];
        if (fs == 0) return b;
        if (fs == 2) return b * 3 / 2;
        return (b * 320) / 294 + (code % 2);
    endfunction

    function automatic parse_result_t parse_header(logic [47:0] hdr, logic [2:0] avail_in);
        parse_result_t r;
        int unsigned b [6];
        int unsigned w, ver, layer, bri, sri, pad, rate, kbps, av, fs, code;
        r = '{codec: CODEC_NONE, size: '0, bad: 1'b0};
        av = (avail_in > 6) ? 6 : avail_in;
        for (int i = 0; i < 6; i++) b[i] = hdr[47 - 8 * i -: 8];
        w = (b[0] << 16) | (b[1] << 8) | b[2];
        if (av >= 3 && (w & 'hFFE000) == 'hFFE000 && (w & 'h1800) != 'h800 &&
            (w & 'h600) != 0 && (w & 'hF0) != 'hF0) begin
            r.codec = CODEC_MPEG;
            ver = (b[1] >> 3) & 3;
            layer = 4 - ((b[1] >> 1) & 3);
            bri = (b[2] >> 4) & 15;
            sri = (b[2] >> 2) & 3;
            pad = (b[2] >> 1) & 1;
            rate = (sri == 0) ? 44100 : (sri == 1) ? 48000 : (sri == 2) ? 32000 : 0;
            if (rate == 0) begin
                r.bad = 1'b1;
            end else begin
                if (ver == 2) rate = rate >> 1;
                else if (ver == 0) rate = rate >> 2;
                kbps = kbps_of(ver == 3, layer, bri);
                if (kbps == 0) r.bad = 1'b1;
                else if (layer == 1) r.size = 14'(((12 * kbps * 1000) / rate + pad) * 4);
                else r.size = 14'((144 * kbps * 1000) / rate + pad);
            end
        end else if (av >= 3 && (w & 'hFFF000) == 'hFFF000 && (w & 'h600) == 0 &&
                     ((b[2] >> 2) & 15) != 15) begin
            r.codec = CODEC_ADTS;
            r.size = 14'(((b[3] & 3) << 11) | (b[4] << 3) | (b[5] >> 5));
        end else if (av >= 6 && (w & 'hFFFF00) == 'h0B7700 && b[5] <= 80) begin
            r.codec = CODEC_AC3;
            fs = b[4] >> 6;
            code = b[4] & 'h3F;
            if (fs == 3 || code > 37) r.bad = 1'b1;
            else r.size = 14'(ac3_size_words(code, fs) * 2);
        end else if (av >= 6 && (w & 'hFFFF00) == 'h0B7700) begin
            r.codec = CODEC_EAC3;
            if ((b[4] & 'hF0) == 'hF0) r.bad = 1'b1;
            else r.size = 14'((((b[2] & 7) << 8) + b[3] + 1) * 2);
        end else if (av >= 3 && (w & 'hFFE000) == ('h2B7 << 13)) begin
            r.codec = CODEC_LATM;
            r.size = 14'(((b[1] & 'h1F) << 8) + b[2] + 3);
        end
        if (r.bad) r.size = '0;
        return r;
    endfunction

    assign pending_count = expected_results.size();

    always @(posedge aclk) begin
        parse_result_t want;
        parse_result_t got;
        if (!aresetn) begin
            fail_count <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_results.push_back(parse_header(s_tdata[47:0], s_tdata[50:48]));
            end
            if (m_tvalid && m_tready) begin
                got = '{codec: codec_t'(m_tdata[2:0]), size: m_tdata[16:3], bad: m_tdata[17]};
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected transfer, expected none, actual %h", $time, got);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (want.codec !== got.codec || want.size !== got.size ||
                        want.bad !== got.bad) begin
                        $display("%0t: mismatch, expected %0d/%0d/%0d, actual %0d/%0d/%0d",
                                 $time, want.codec, want.size, want.bad,
                                 got.codec, got.size, got.bad);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

FILE: sim/audio_frame_header_parser_tb.sv
// Testbench top that drives headers into the audio frame header parser and reports the verdict.
module audio_frame_header_parser_tb;
    import afhp_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    int          fail_count;
    int          pending_count;
    int          send_idle_pct;
    int          recv_idle_pct;
    bit          hold_req;
    bit          hold_taken;
    int          idle_count;

    audio_frame_header_parser dut (.*);

    audio_frame_header_checker checker_inst (.*);

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                m_tready <= 1'b0;
                repeat (60) @(posedge aclk);
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial begin
        idle_count = 0;
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_count = 0;
            else idle_count = idle_count + 1;
            if (idle_count > 5000) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    function automatic logic [47:0] random_header();
        logic [47:0] h;
        h = 48'({$urandom, $urandom});
        case ($urandom_range(7))
            0: h[47:37] = 11'h7FF;
            1: begin h[47:36] = 12'hFFF; h[34:33] = 2'b00; end
            2: h[47:32] = 16'h0B77;
            3: begin h[47:32] = 16'h0B77; h[7:0] = 8'($urandom_range(80)); end
            4: h[47:37] = 11'h2B7;
            5: begin h[47:37] = 11'h7FF; h[36:32] = 5'h1F; end
            default: ;
        endcase
        return h;
    endfunction

    task automatic send_header(logic [47:0] hdr, logic [2:0] avail);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {5'b0, avail, hdr};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic pause_until_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        hold_req = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_header(48'h0, 3'd0);
        send_header('1, 3'd7);
        send_header(48'hFFFB_9064_0000, 3'd3);
        send_header(48'hFFFB_9064_0000, 3'd2);
        send_header(48'hFFE3_9064_0000, 3'd6);
        send_header(48'hFFF3_9264_0000, 3'd6);
        send_header(48'hFFFF_E000_0000, 3'd6);
        send_header(48'hFFFB_9C00_0000, 3'd6);
        send_header(48'hFFFB_0000_0000, 3'd6);
        send_header(48'hFFF1_5080_2E7F, 3'd3);
        send_header(48'hFFF1_5080_0000, 3'd6);
        send_header(48'hFFF1_3C80_2E7F, 3'd6);
        send_header(48'h0B77_0000_0000, 3'd6);
        send_header(48'h0B77_0000_2550, 3'd6);
        send_header(48'h0B77_0000_C000, 3'd6);
        send_header(48'h0B77_0000_2650, 3'd6);
        send_header(48'h0B77_0000_6550, 3'd6);
        send_header(48'h0B77_0000_2650, 3'd5);
        send_header(48'h0B77_07FF_0060, 3'd6);
        send_header(48'h0B77_0000_F060, 3'd6);
        send_header(48'h56FF_FF00_0000, 3'd3);
        send_header(48'h56E0_0000_0000, 3'd6);
        pause_until_drained();

        hold_req = 1'b1;
        for (int i = 0; i < 40; i++) send_header(random_header(), 3'($urandom_range(7)));
        pause_until_drained();

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 20 : (phase == 1) ? 57 : 0;
            recv_idle_pct = (phase == 0) ? 57 : (phase == 1) ? 20 : 0;
            for (int i = 0; i < 120; i++) begin
                send_header(random_header(), 3'($urandom_range(7)));
                if ($urandom_range(99) == 0) pause_until_drained();
            end
        end
        recv_idle_pct = 0;
        pause_until_drained();
        repeat (20) @(posedge aclk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
